### hdl/s2a_pkg.sv
// Shared types, key codes and character tables for the scan code decoder.
// Depends on nothing; imported by s2a_decode and scancode_to_ascii_decoder_core.
`timescale 1ns / 1ps

package s2a_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned KeyW  = 7;
  localparam int unsigned CharW = 7;

  // Make codes with special handling
  localparam logic [KeyW-1:0] KEY_TAB    = 7'h0F;
  localparam logic [KeyW-1:0] KEY_ENTER  = 7'h1C;
  localparam logic [KeyW-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [KeyW-1:0] KEY_CAPS   = 7'h3A;

  // Control characters
  localparam logic [CharW-1:0] CHAR_NONE = 7'd0;
  localparam logic [CharW-1:0] CHAR_TAB  = 7'd9;
  localparam logic [CharW-1:0] CHAR_LF   = 7'd10;

  localparam logic [CharW-1:0] CHAR_LOWER_A = 7'd97;
  localparam logic [CharW-1:0] CHAR_LOWER_Z = 7'd122;
  localparam logic [CharW-1:0] CASE_DELTA   = 7'd32;

  typedef struct packed {
    logic caps_active;
    logic shift_held;
  } s2a_flags_t;

  // Unshifted ASCII for each key number; unmapped keys give zero
  function automatic logic [CharW-1:0] key_lookup(input logic [KeyW-1:0] key);
    logic [CharW-1:0] ch;
    unique case (key)
      7'd1:  ch = 7'd27;   // escape
      7'd2:  ch = 7'd49;   // 1
      7'd3:  ch = 7'd50;   // 2
      7'd4:  ch = 7'd51;   // 3
      7'd5:  ch = 7'd52;   // 4
      7'd6:  ch = 7'd53;   // 5
      7'd7:  ch = 7'd54;   // 6
      7'd8:  ch = 7'd55;   // 7
      7'd9:  ch = 7'd56;   // 8
      7'd10: ch = 7'd57;   // 9
      7'd11: ch = 7'd48;   // 0
      7'd12: ch = 7'd45;   // -
      7'd13: ch = 7'd61;   // =
      7'd14: ch = 7'd8;    // backspace
      7'd15: ch = 7'd9;    // tab
      7'd16: ch = 7'd113;  // q
      7'd17: ch = 7'd119;  // w
      7'd18: ch = 7'd101;  // e
      7'd19: ch = 7'd114;  // r
      7'd20: ch = 7'd116;  // t
      7'd21: ch = 7'd121;  // y
      7'd22: ch = 7'd117;  // u
      7'd23: ch = 7'd105;  // i
      7'd24: ch = 7'd111;  // o
      7'd25: ch = 7'd112;  // p
      7'd26: ch = 7'd91;   // [
      7'd27: ch = 7'd93;   // ]
      7'd28: ch = 7'd10;   // newline
      7'd30: ch = 7'd97;   // a
      7'd31: ch = 7'd115;  // s
      7'd32: ch = 7'd100;  // d
      7'd33: ch = 7'd102;  // f
      7'd34: ch = 7'd103;  // g
      7'd35: ch = 7'd104;  // h
      7'd36: ch = 7'd106;  // j
      7'd37: ch = 7'd107;  // k
      7'd38: ch = 7'd108;  // l
      7'd39: ch = 7'd59;   // ;
      7'd40: ch = 7'd39;   // apostrophe
      7'd41: ch = 7'd96;   // backtick
      7'd43: ch = 7'd92;   // backslash
      7'd44: ch = 7'd122;  // z
      7'd45: ch = 7'd120;  // x
      7'd46: ch = 7'd99;   // c
      7'd47: ch = 7'd118;  // v
      7'd48: ch = 7'd98;   // b
      7'd49: ch = 7'd110;  // n
      7'd50: ch = 7'd109;  // m
      7'd51: ch = 7'd44;   // ,
      7'd52: ch = 7'd46;   // .
      7'd53: ch = 7'd47;   // /
      7'd55: ch = 7'd42;   // keypad *
      7'd57: ch = 7'd32;   // space
      7'd74: ch = 7'd45;   // keypad -
      7'd78: ch = 7'd43;   // keypad +
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

  function automatic logic [CharW-1:0] to_upper(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

  // Shifted symbol map; letters go to uppercase
  function automatic logic [CharW-1:0] shifted(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    unique case (c)
      7'd49:  r = 7'd33;   // 1 -> !
      7'd50:  r = 7'd64;   // 2 -> @
      7'd51:  r = 7'd35;   // 3 -> #
      7'd52:  r = 7'd36;   // 4 -> $
      7'd53:  r = 7'd37;   // 5 -> %
      7'd54:  r = 7'd94;   // 6 -> ^
      7'd55:  r = 7'd38;   // 7 -> &
      7'd56:  r = 7'd42;   // 8 -> *
      7'd57:  r = 7'd40;   // 9 -> (
      7'd48:  r = 7'd41;   // 0 -> )
      7'd45:  r = 7'd95;   // - -> _
      7'd61:  r = 7'd43;   // = -> +
      7'd91:  r = 7'd123;  // [ -> {
      7'd93:  r = 7'd125;  // ] -> }
      7'd59:  r = 7'd58;   // ; -> :
      7'd39:  r = 7'd34;   // apostrophe -> double quote
      7'd44:  r = 7'd60;   // , -> <
      7'd46:  r = 7'd62;   // . -> >
      7'd47:  r = 7'd63;   // / -> ?
      7'd92:  r = 7'd124;  // backslash -> bar
      7'd96:  r = 7'd126;  // backtick -> tilde
      default: r = to_upper(c);
    endcase
    return r;
  endfunction

endpackage

### hdl/scancode_to_ascii_decoder_core.sv
// Top level of the set-1 scan code to ASCII decoder: stream ports and pipeline registers.
// Depends on s2a_pkg and s2a_decode.
`timescale 1ns / 1ps

// Takes one set-1 scan code byte per request on the slave stream and returns one
// ASCII character (zero when the code gives none) per request on the master stream,
// in order. Caps lock and left shift are tracked internally and cleared by reset.
// Each request passes an input register and then a result register, and a new
// request is taken every cycle as long as the master side keeps accepting; the
// table lookup between the two registers sets the clock limit.
module scancode_to_ascii_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] scan_code
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [6:0] character, [7] zero
);
  import s2a_pkg::*;

  logic               in_valid_d, in_valid_q;
  logic [CodeW-1:0]   code_q;
  logic               out_valid_d, out_valid_q;
  logic [CharW-1:0]   char_q;
  logic [CharW-1:0]   char_w;
  logic               out_free_w;
  logic               advance_w;
  logic               s_accept_w;
  s2a_flags_t         flags_w;

  // Pipeline handshake
  assign out_free_w      = ~out_valid_q | m_axis_tready_i;
  assign advance_w       = in_valid_q & out_free_w;
  assign s_axis_tready_o = ~in_valid_q | out_free_w;
  assign s_accept_w      = s_axis_tvalid_i & s_axis_tready_o;

  assign in_valid_d  = s_accept_w | (in_valid_q & ~advance_w);
  assign out_valid_d = advance_w | (out_valid_q & ~m_axis_tready_i);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input request
  always_ff @(posedge clk_i) begin
    if (s_accept_w) begin
      code_q <= s_axis_tdata_i;
    end
  end

  s2a_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance_w),
    .code_i    (code_q),
    .char_o    (char_w),
    .flags_o   (flags_w)
  );

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (advance_w) begin
      char_q <= char_w;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, char_q};

`ifndef SYNTHESIS
  a_shift_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_w && code_q == {1'b0, KEY_LSHIFT} |=> flags_w.shift_held)
    else $error("left shift make did not set shift flag");

  a_caps_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_w && code_q == {1'b0, KEY_CAPS}
      |=> flags_w.caps_active != $past(flags_w.caps_active))
    else $error("caps lock make did not toggle caps flag");

  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_w && code_q[CodeW-1] |=> out_valid_q && char_q == CHAR_NONE)
    else $error("release code produced a nonzero character");

  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free_w |=> in_valid_q && $stable(code_q))
    else $error("stalled input request was lost or changed");
`endif

endmodule

### hdl/s2a_decode.sv
// Scan code decode: caps lock and left shift flags plus the character lookup.
// Depends on s2a_pkg.
`timescale 1ns / 1ps

module s2a_decode (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,  // request moves to the result register
  input  logic [s2a_pkg::CodeW-1:0] code_i,
  output logic [s2a_pkg::CharW-1:0] char_o,
  output s2a_pkg::s2a_flags_t      flags_o
);
  import s2a_pkg::*;

  s2a_flags_t       flags_d, flags_q;
  logic             release_w;
  logic [KeyW-1:0]  key_w;
  logic [CharW-1:0] base_w;

  assign release_w = code_i[CodeW-1];
  assign key_w     = code_i[KeyW-1:0];
  assign base_w    = key_lookup(key_w);

  // Flag update for the code in the input register
  always_comb begin
    flags_d = flags_q;
    if (release_w) begin
      if (key_w == KEY_LSHIFT) begin
        flags_d.shift_held = 1'b0;
      end
    end else if (key_w == KEY_CAPS) begin
      flags_d.caps_active = ~flags_q.caps_active;
    end else if (key_w == KEY_LSHIFT) begin
      flags_d.shift_held = 1'b1;
    end
  end

  // Character for the code under the current flags
  always_comb begin
    if (release_w || key_w == KEY_CAPS || key_w == KEY_LSHIFT) begin
      char_o = CHAR_NONE;
    end else if (key_w == KEY_ENTER) begin
      char_o = CHAR_LF;
    end else if (key_w == KEY_TAB) begin
      char_o = CHAR_TAB;
    end else if (flags_q.shift_held) begin
      char_o = shifted(base_w);
    end else if (flags_q.caps_active) begin
      char_o = to_upper(base_w);
    end else begin
      char_o = base_w;
    end
  end

  // Commit flags only when the request advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (advance_i) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule
